// ===== rtl/core/sha0_message_digest_defines.svh =====
// Assertion macros used by the SHA-0 digest sequencer.
`ifndef SHA0_MESSAGE_DIGEST_DEFINES_SVH
`define SHA0_MESSAGE_DIGEST_DEFINES_SVH

// Checks a property on every rising clk_i edge outside reset.
`define SHA0_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds.
`define SHA0_ASSERT_NEVER(lbl, cond, msg) \
  `SHA0_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/sha0_pkg.sv =====
// Types, constants and the round function of the SHA-0 digest block.
package sha0_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_LEN,
    ST_OUT
  } sha0_state_e;

  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        pad_len;
    logic        len_only;
    logic        load_wv;
    logic        round;
    logic        add;
    logic        out_shift;
    logic        load_iv;
    logic        early;
    logic [1:0]  stage;
    logic [5:0]  pos;
    logic [63:0] bit_len;
  } sha0_ctl_t;

  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [4:0][31:0] INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] LAST_WORD   = 7'd4;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LEN_POS     = 6'd56;

  localparam logic [1:0] STAGE_CH  = 2'd0;
  localparam logic [1:0] STAGE_P1  = 2'd1;
  localparam logic [1:0] STAGE_MAJ = 2'd2;
  localparam logic [1:0] STAGE_P2  = 2'd3;

  function automatic logic [31:0] round_f(logic [1:0] stage, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    case (stage)
      STAGE_CH:  f = (b & c) | (~b & d);
      STAGE_MAJ: f = (b & c) | (b & d) | (c & d);
      default:   f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/sha0_ctrl.sv =====
// Sequencer of the SHA-0 digest block: byte count, rounds and digest output.
`include "sha0_message_digest_defines.svh"

module sha0_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha0_pkg::sha0_ctl_t ctl_o,
  output logic [2:0]        word_index_o,
  output logic              last_word_o
);
  import sha0_pkg::*;

  sha0_state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [60:0] count_q, count_d;
  logic        fin_q, fin_d;
  logic        lenp_q, lenp_d;
  logic [5:0]  pos;
  logic        in_acc;

  assign pos    = count_q[5:0];
  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    count_d = count_q;
    fin_d   = fin_q;
    lenp_d  = lenp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            fin_d   = 1'b1;
            state_d = ST_PAD;
          end else begin
            count_d = count_q + 61'd1;
            if (pos == LAST_POS) begin
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_PAD: begin
        lenp_d  = (pos >= LEN_POS);
        state_d = ST_INIT;
      end
      ST_INIT: begin
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_q == LAST_ROUND) begin
          cnt_d   = '0;
          state_d = ST_ADD;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_ADD: begin
        if (cnt_q == LAST_WORD) begin
          cnt_d = '0;
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (lenp_q) begin
            lenp_d  = 1'b0;
            state_d = ST_LEN;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_LEN: begin
        state_d = ST_INIT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (cnt_q == LAST_WORD) begin
            cnt_d   = '0;
            count_d = '0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    out_valid_o     = (state_q == ST_OUT);
    word_index_o    = cnt_q[2:0];
    last_word_o     = (cnt_q == LAST_WORD);
    ctl_o           = '0;
    ctl_o.pos       = pos;
    ctl_o.bit_len   = {count_q, 3'b000};
    ctl_o.early     = (cnt_q < 7'd16);
    if (cnt_q < 7'd20) begin
      ctl_o.stage = STAGE_CH;
    end else if (cnt_q < 7'd40) begin
      ctl_o.stage = STAGE_P1;
    end else if (cnt_q < 7'd60) begin
      ctl_o.stage = STAGE_MAJ;
    end else begin
      ctl_o.stage = STAGE_P2;
    end
    unique case (state_q)
      ST_IDLE:  ctl_o.wr_byte = in_valid_i && !mode_i;
      ST_PAD: begin
        ctl_o.pad     = 1'b1;
        ctl_o.pad_len = (pos < LEN_POS);
      end
      ST_INIT:  ctl_o.load_wv  = 1'b1;
      ST_ROUND: ctl_o.round    = 1'b1;
      ST_ADD:   ctl_o.add      = 1'b1;
      ST_LEN:   ctl_o.len_only = 1'b1;
      ST_OUT: begin
        ctl_o.out_shift = out_ready_i;
        ctl_o.load_iv   = out_ready_i && (cnt_q == LAST_WORD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      fin_q   <= 1'b0;
      lenp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      fin_q   <= fin_d;
      lenp_q  <= lenp_d;
    end
  end

  `SHA0_ASSERT_NEVER(a_ready_and_valid, in_ready_o && out_valid_o, "ready during output")
  `SHA0_ASSERT(a_end_to_pad, in_valid_i && in_ready_o && mode_i |=> state_q == ST_PAD,
    "end mark did not start padding")
  `SHA0_ASSERT_NEVER(a_round_range, state_q == ST_ROUND && cnt_q > LAST_ROUND,
    "round count out of range")
  `SHA0_ASSERT_NEVER(a_out_index, state_q == ST_OUT && cnt_q > LAST_WORD,
    "word index out of range")

endmodule

// ===== rtl/core/sha0_sched.sv =====
// Message block register of the SHA-0 digest block: byte gather, padding, schedule.
module sha0_sched (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha0_pkg::sha0_ctl_t ctl_i,
  input  logic [7:0]          message_byte_i,
  output logic [31:0]         w_o
);
  import sha0_pkg::*;

  logic [15:0][31:0] w_q, w_d;
  logic [31:0]       w_new;

  assign w_new = ctl_i.early ? w_q[0] : (w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
  assign w_o   = w_new;

  always_comb begin
    logic [5:0] bi;
    w_d = w_q;
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        bi = 6'(j * 4 + k);
        if (ctl_i.wr_byte && bi == ctl_i.pos) begin
          w_d[j][(3 - k) * 8 +: 8] = message_byte_i;
        end
        if (ctl_i.pad) begin
          if (bi == ctl_i.pos) begin
            w_d[j][(3 - k) * 8 +: 8] = PAD_BYTE;
          end else if (bi > ctl_i.pos) begin
            w_d[j][(3 - k) * 8 +: 8] = 8'h00;
          end
        end
      end
    end
    if (ctl_i.len_only) begin
      w_d = '0;
    end
    if (ctl_i.len_only || ctl_i.pad_len) begin
      w_d[14] = ctl_i.bit_len[63:32];
      w_d[15] = ctl_i.bit_len[31:0];
    end
    if (ctl_i.round) begin
      for (int j = 0; j < 15; j++) begin
        w_d[j] = w_q[j + 1];
      end
      w_d[15] = w_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q <= w_d;
    end
  end

endmodule

// ===== rtl/core/sha0_round_unit.sv =====
// Working variables, chaining value and the shared adder of the SHA-0 digest block.
module sha0_round_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha0_pkg::sha0_ctl_t ctl_i,
  input  logic [31:0]         w_i,
  output logic [31:0]         digest_word_o
);
  import sha0_pkg::*;

  logic [4:0][31:0] wv_q, wv_d;
  logic [4:0][31:0] chain_q, chain_d;
  logic [31:0]      op0, op1, op2, op3, op4, sum;

  always_comb begin
    if (ctl_i.add) begin
      op0 = chain_q[0];
      op1 = wv_q[0];
      op2 = '0;
      op3 = '0;
      op4 = '0;
    end else begin
      op0 = {wv_q[0][26:0], wv_q[0][31:27]};
      op1 = round_f(ctl_i.stage, wv_q[1], wv_q[2], wv_q[3]);
      op2 = wv_q[4];
      op3 = ROUND_K[ctl_i.stage];
      op4 = w_i;
    end
    sum = op0 + op1 + op2 + op3 + op4;
  end

  always_comb begin
    wv_d    = wv_q;
    chain_d = chain_q;
    if (ctl_i.load_wv) begin
      wv_d = chain_q;
    end
    if (ctl_i.round) begin
      wv_d[4] = wv_q[3];
      wv_d[3] = wv_q[2];
      wv_d[2] = {wv_q[1][1:0], wv_q[1][31:2]};
      wv_d[1] = wv_q[0];
      wv_d[0] = sum;
    end
    if (ctl_i.add) begin
      for (int i = 0; i < 4; i++) begin
        chain_d[i] = chain_q[i + 1];
        wv_d[i]    = wv_q[i + 1];
      end
      chain_d[4] = sum;
      wv_d[4]    = wv_q[0];
    end
    if (ctl_i.out_shift) begin
      for (int i = 0; i < 4; i++) begin
        chain_d[i] = chain_q[i + 1];
      end
      chain_d[4] = chain_q[0];
    end
    if (ctl_i.load_iv) begin
      chain_d = INIT_CHAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= INIT_CHAIN;
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

  assign digest_word_o = chain_q[0];

endmodule

// ===== rtl/core/sha0_message_digest.sv =====
// Top level of the SHA-0 digest block.
//
//   Channel  Direction  Handshake                  Word
//   in       input      in_valid_i / in_ready_o    mode_i, message_byte_i
//   out      output     out_valid_o / out_ready_i  digest_word_o, word_index_o, last_word_o
//
// An appended byte is stored as it is accepted; the 64th byte of a block then starts
// a compression (one load, 80 rounds through the single round adder, five chaining adds).
// An end mark takes one padding step plus one block, or two blocks and one length
// step when fewer than nine bytes remain, then five output words at one per accepted cycle.
// Reset clears the sequencer and loads the initial chaining value; no clearing pass.
// A stalled output holds the sequencer; no input is taken while output is pending.
module sha0_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  message_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha0_pkg::*;

  sha0_ctl_t   ctl;
  logic [31:0] w;

  sha0_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ctl_o        (ctl),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  sha0_sched u_sched (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .message_byte_i (message_byte_i),
    .w_o            (w)
  );

  sha0_round_unit u_round (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .w_i           (w),
    .digest_word_o (digest_word_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the SHA-0 message digest block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_END    = 1'b1;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [4:0][31:0] SHA_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [3:0][31:0] SHA_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_WORDS  = 72;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  class digest_board;
    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    logic [60:0] msg_bytes;
    digest_exp_t expected_q [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 5; i++) chain[i] = SHA_IV[i];
      msg_bytes = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, wt, sum;
      for (int t = 0; t < 16; t++) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
          w[t % 16] = wt;
        end
        if (t < 20) f = (b & c) | (~b & d);
        else if (t >= 40 && t < 60) f = (b & c) | (b & d) | (c & d);
        else f = b ^ c ^ d;
        sum = {a[26:0], a[31:27]} + f + e + SHA_K[t / 20] + wt;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_word(logic mode, logic [7:0] msg_byte);
      int          pos;
      logic [63:0] bits;
      digest_exp_t item;
      pos = int'(msg_bytes[5:0]);
      if (mode == MODE_APPEND) begin
        blk[pos] = msg_byte;
        msg_bytes = msg_bytes + 61'd1;
        if (pos == 63) compress();
        return;
      end
      blk[pos] = PAD_MARK;
      for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      bits = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[63 - 8 * i -: 8];
      compress();
      for (int i = 0; i < 5; i++) begin
        item.word  = chain[i];
        item.index = 3'(i);
        item.last  = (i == 4);
        expected_q.push_back(item);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_exp_t exp_item;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, got %h index %0d last %0b",
                 $time, word, index, last);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (word !== exp_item.word) begin
        $display("%0t: digest_word expected %h got %h", $time, exp_item.word, word);
        errors++;
      end
      if (index !== exp_item.index) begin
        $display("%0t: word_index expected %0d got %0d", $time, exp_item.index, index);
        errors++;
      end
      if (last !== exp_item.last) begin
        $display("%0t: last_word expected %0b got %0b", $time, exp_item.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        mode_i         = MODE_APPEND;
  logic [7:0]  message_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          words_sent     = 0;
  int          quiet_cycles   = 0;
  digest_board board          = new();

  sha0_message_digest dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .message_byte_i (message_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_word(digest_word_o, word_index_o, last_word_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(logic mode, logic [7:0] msg_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    message_byte_i <= msg_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_word(mode, msg_byte);
    words_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(MODE_APPEND, 8'($urandom_range(255)));
    send_word(MODE_END, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_length();
    if ($urandom_range(2) != 0) return $urandom_range(0, 70);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 55;
      2:       return 56;
      3:       return 57;
      4:       return 63;
      5:       return 64;
      6:       return 119;
      default: return 120;
    endcase
  endfunction

  initial begin
    int phase_start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(MODE_END, 8'hFF);
    send_word(MODE_APPEND, 8'h00);
    send_word(MODE_APPEND, 8'hFF);
    send_word(MODE_END, 8'h00);
    send_word(MODE_APPEND, 8'h61);
    send_word(MODE_APPEND, 8'h62);
    send_word(MODE_APPEND, 8'h63);
    send_word(MODE_END, 8'hA5);
    send_word(MODE_END, 8'h5A);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_message(pick_length());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d digest words never arrived", $time, board.pending());
    end
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha0_pkg.sv
rtl/core/sha0_ctrl.sv
rtl/core/sha0_sched.sv
rtl/core/sha0_round_unit.sv
rtl/core/sha0_message_digest.sv
tb/testbench.sv
